// ===== design/group_elastic_net_penalty_macros.svh =====
// Assertion macros for the group elastic-net penalty block.
// Used by the port checker; needs nothing else.
`ifndef GROUP_ELASTIC_NET_PENALTY_MACROS_SVH
`define GROUP_ELASTIC_NET_PENALTY_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define GENNP_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GENNP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/gennp_pkg.sv =====
// Shared types and constants of the group elastic-net penalty block.
// No dependencies.
package gennp_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int ROOT_STEPS = 20;

   localparam logic [15:0] ONE_Q15     = 16'h8000;
   localparam logic [15:0] ALPHA_RESET = 16'h8000;
   localparam logic [39:0] SQ_MAX      = 40'hFF_FFFF_FFFF;
   localparam logic [47:0] TOTAL_MAX   = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic signed [15:0] coefficient;
      logic [15:0]        group_weight;
      logic               end_of_group;
      logic               end_of_row;
   } req_type;

   typedef struct packed {
      logic [47:0] penalty;
      logic        saturated;
   } rsp_type;

   // One closed group handed from the front to the back.
   typedef struct packed {
      logic [39:0] square_sum;
      logic [15:0] weight;
      logic        end_of_row;
      logic        overflow;
   } job_type;

endpackage

// ===== design/gennp_fifo.sv =====
// Small job queue between the front and back parts.
// Depends on gennp_pkg for the job type.
module gennp_fifo #(
   parameter int DEPTH = gennp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gennp_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output gennp_pkg::job_type pop_job,
   output logic              empty
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   gennp_pkg::job_type mem_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== design/gennp_front.sv =====
// Front part: takes coefficient beats, accumulates the group's sum of squares
// and queues one job per closed group. Depends on gennp_pkg.
module gennp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  gennp_pkg::req_type  req_data,
   input  logic               queue_full,
   output logic               push,
   output gennp_pkg::job_type  push_job
);

   logic [39:0] sum_ff, sum_in;
   logic        grp_ovf_ff, grp_ovf_in;
   logic [16:0] mag;
   logic [33:0] square;
   logic [40:0] sum_ext;
   logic        carry;
   logic [39:0] new_sum;
   logic        new_ovf;
   logic        accept;
   logic        closes;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign closes    = req_data.end_of_group || req_data.end_of_row;

   always_comb begin
      // magnitude of the most negative code is 2^15, which still fits in 16 bits
      mag = req_data.coefficient[15] ? (17'd0 - {1'b1, req_data.coefficient})
                                     : {1'b0, req_data.coefficient};
      square  = 34'(mag) * 34'(mag);
      sum_ext = {1'b0, sum_ff} + 41'(square);
      carry   = sum_ext[40];
      new_sum = carry ? gennp_pkg::SQ_MAX : sum_ext[39:0];
      new_ovf = grp_ovf_ff || carry;

      sum_in     = sum_ff;
      grp_ovf_in = grp_ovf_ff;
      if (accept) begin
         if (closes) begin
            sum_in     = '0;
            grp_ovf_in = 1'b0;
         end else begin
            sum_in     = new_sum;
            grp_ovf_in = new_ovf;
         end
      end
   end

   assign push                = accept && closes;
   assign push_job.square_sum = new_sum;
   assign push_job.weight     = req_data.group_weight;
   assign push_job.end_of_row = req_data.end_of_row;
   assign push_job.overflow   = new_ovf;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         grp_ovf_ff <= 1'b0;
      end else begin
         sum_ff     <= sum_in;
         grp_ovf_ff <= grp_ovf_in;
      end
   end

endmodule

// ===== design/gennp_back.sv =====
// Back part: per queued group takes the integer square root, forms the
// weighted elastic-net term, adds it to the row total and emits at row end.
// Depends on gennp_pkg.
module gennp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [15:0]        alpha,
   input  logic               queue_empty,
   input  gennp_pkg::job_type  pop_job,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output gennp_pkg::rsp_type  rsp_data
);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_ROOT    = 9'b000000010,
      ST_SCALE   = 9'b000000100,
      ST_MIX     = 9'b000001000,
      ST_PROD_LO = 9'b000010000,
      ST_PROD_HI = 9'b000100000,
      ST_TERM    = 9'b001000000,
      ST_TOTAL   = 9'b010000000,
      ST_EMIT    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [39:0] rad_ff, rad_in;
   logic [20:0] rem_ff, rem_in;
   logic [19:0] root_ff, root_in;
   logic [4:0]  step_ff, step_in;
   logic [15:0] weight_ff, weight_in;
   logic        eor_ff, eor_in;
   logic        job_ovf_ff, job_ovf_in;
   logic [35:0] wn_ff, wn_in;
   logic [35:0] mix_ff, mix_in;
   logic [35:0] inner_ff, inner_in;
   logic [53:0] plo_ff, plo_in;
   logic [53:0] phi_ff, phi_in;
   logic [43:0] term_ff, term_in;
   logic [47:0] total_ff, total_in;
   logic        row_ovf_ff, row_ovf_in;
   gennp_pkg::rsp_type rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [15:0] alpha_used;
   logic [22:0] rem_shift;
   logic [22:0] trial;
   logic [71:0] product;
   logic [48:0] total_ext;
   logic        out_free;

   assign alpha_used = (alpha > gennp_pkg::ONE_Q15) ? gennp_pkg::ONE_Q15 : alpha;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign pop        = (state_ff == ST_IDLE) && !queue_empty;

   always_comb begin
      rem_shift = {rem_ff, rad_ff[39:38]};
      trial     = {1'b0, root_ff, 2'b01};
      product   = {18'd0, plo_ff} + {phi_ff, 18'd0};
      total_ext = {1'b0, total_ff} + 49'(term_ff);

      state_in     = state_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      step_in      = step_ff;
      weight_in    = weight_ff;
      eor_in       = eor_ff;
      job_ovf_in   = job_ovf_ff;
      wn_in        = wn_ff;
      mix_in       = mix_ff;
      inner_in     = inner_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      term_in      = term_ff;
      total_in     = total_ff;
      row_ovf_in   = row_ovf_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               rad_in     = pop_job.square_sum;
               rem_in     = '0;
               root_in    = '0;
               step_in    = '0;
               weight_in  = pop_job.weight;
               eor_in     = pop_job.end_of_row;
               job_ovf_in = pop_job.overflow;
               state_in   = ST_ROOT;
            end
         end
         ST_ROOT: begin
            // one root bit per cycle, two radicand bits shifted in
            if (rem_shift >= trial) begin
               rem_in  = 21'(rem_shift - trial);
               root_in = {root_ff[18:0], 1'b1};
            end else begin
               rem_in  = rem_shift[20:0];
               root_in = {root_ff[18:0], 1'b0};
            end
            rad_in  = {rad_ff[37:0], 2'b00};
            step_in = step_ff + 1'b1;
            if (step_ff == 5'(gennp_pkg::ROOT_STEPS - 1)) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            wn_in    = {20'd0, weight_ff} * {16'd0, root_ff};
            mix_in   = {20'd0, 16'(gennp_pkg::ONE_Q15 - alpha_used)} * {16'd0, root_ff};
            state_in = ST_MIX;
         end
         ST_MIX: begin
            inner_in = {7'd0, alpha_used, 13'd0} + mix_ff;
            state_in = ST_PROD_LO;
         end
         ST_PROD_LO: begin
            plo_in   = 54'(wn_ff) * 54'(inner_ff[17:0]);
            state_in = ST_PROD_HI;
         end
         ST_PROD_HI: begin
            phi_in   = 54'(wn_ff) * 54'(inner_ff[35:18]);
            state_in = ST_TERM;
         end
         ST_TERM: begin
            term_in  = product[71:28];
            state_in = ST_TOTAL;
         end
         ST_TOTAL: begin
            if (total_ext[48]) begin
               total_in = gennp_pkg::TOTAL_MAX;
            end else begin
               total_in = total_ext[47:0];
            end
            row_ovf_in = row_ovf_ff || job_ovf_ff || total_ext[48];
            state_in   = eor_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_in.penalty   = total_ff;
               rsp_in.saturated = row_ovf_ff;
               rsp_valid_in     = 1'b1;
               total_in         = '0;
               row_ovf_in       = 1'b0;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         row_ovf_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         row_ovf_ff   <= row_ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff     <= rad_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      step_ff    <= step_in;
      weight_ff  <= weight_in;
      eor_ff     <= eor_in;
      job_ovf_ff <= job_ovf_in;
      wn_ff      <= wn_in;
      mix_ff     <= mix_in;
      inner_ff   <= inner_in;
      plo_ff     <= plo_in;
      phi_ff     <= phi_in;
      term_ff    <= term_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== design/group_elastic_net_penalty.sv =====
// Group elastic-net penalty, top level: alpha register, front, queue, back.
// Depends on gennp_pkg, gennp_front, gennp_fifo and gennp_back.
//
// Usage: stream one row's coefficients on req_ as valid/ready beats, each
// with its group weight and end-of-group / end-of-row marks. One rsp_ beat
// carries the row penalty (24 fraction bits) and a saturation flag; it is
// produced only for a beat marked end of row.
// Throughput: the front takes one coefficient per cycle while the job queue
// has room. The back works on one closed group at a time and pops the next
// only when back in idle: a pop, the bit-serial square root, then scale, sum,
// two partial products, term and total; a row end adds a state to load the
// output. Short groups back up in the queue and then stall req_ready.
// Result path: the row result passes the queue, the back states and the
// output register, behind any groups still queued ahead of it.
// Reset clears accumulators, queue and output; alpha returns to 1.0.
// A stalled receiver holds the result in the output register; the back waits
// at row end and the front keeps filling the queue until it is full.
// csr_wr_en writes the alpha register; write it only while the block is idle.
module group_elastic_net_penalty #(
   parameter int QUEUE_DEPTH = gennp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  gennp_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output gennp_pkg::rsp_type  rsp_data,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);

   logic [15:0] alpha_ff;
   logic        q_push, q_pop, q_full, q_empty;
   gennp_pkg::job_type q_in_job, q_out_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= gennp_pkg::ALPHA_RESET;
      end else if (csr_wr_en) begin
         alpha_ff <= csr_wr_data;
      end
   end

   gennp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (q_full),
      .push       (q_push),
      .push_job   (q_in_job)
   );

   gennp_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_in_job),
      .full     (q_full),
      .pop      (q_pop),
      .pop_job  (q_out_job),
      .empty    (q_empty)
   );

   gennp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .alpha       (alpha_ff),
      .queue_empty (q_empty),
      .pop_job     (q_out_job),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== design/gennp_checker.sv =====
// Port-level checks of the group elastic-net penalty block, bound to the top.
// Depends on gennp_pkg and group_elastic_net_penalty_macros.svh.
`include "group_elastic_net_penalty_macros.svh"

module gennp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input gennp_pkg::req_type  req_data,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input gennp_pkg::rsp_type  rsp_data
);

   `GENNP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid,
      "result beat dropped while stalled")
   `GENNP_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready,
      $stable(rsp_data), "result payload changed while stalled")
   `GENNP_ASSERT_SAME(a_rsp_after_reset, clock, reset, $past(reset), !rsp_valid,
      "result beat right after reset")
   `GENNP_ASSERT_SAME(a_rsp_not_instant, clock, reset, $rose(rsp_valid),
      !$past(req_valid && req_ready && req_data.end_of_row), "result one cycle after row end")

endmodule

bind group_elastic_net_penalty gennp_checker u_checker (.*);

// ===== dv/tb_group_elastic_net_penalty.sv =====
// Self-checking testbench for group_elastic_net_penalty.
// Streams directed and random rows of coefficients with random idling on both channels.
// Needs gennp_pkg and the group_elastic_net_penalty RTL.
`timescale 1ns / 100ps

module tb_group_elastic_net_penalty;
   import gennp_pkg::*;

   typedef enum logic {STEP_BEAT, STEP_ALPHA} plan_kind_type;

   typedef struct packed {
      plan_kind_type kind;
      logic [15:0]   alpha;
      req_type       beat;
      logic          pinned;
      rsp_type       want;
   } plan_step_type;

   localparam int DIRECTED_STEPS = 23;
   localparam int SETTLE_CYCLES  = 40;
   localparam int CLIP_GROUPS    = 1;
   localparam int CLIP_MEMBERS   = 1024;
   localparam int PHASE_BEATS    = 40;
   localparam int PRINT_CAP      = 100;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   // predictor state
   logic [15:0] alpha_shadow = ALPHA_RESET;
   logic [39:0] acc_square_sum = '0;
   logic [47:0] acc_row_total = '0;
   logic        acc_clipped = 1'b0;
   rsp_type     penalty_due [$];

   int mismatch_count = 0;
   int rows_checked = 0;
   bit quiet_tail = 1'b0;
   int stall_left = 0;

   // Expected values typed in only where they read off directly; others are predicted.
   plan_step_type directed_plan [DIRECTED_STEPS] = '{
      '{STEP_BEAT,  16'h0000, '{16'sh0000, 16'h0000, 1'b0, 1'b1}, 1'b1, '{48'h0, 1'b0}},
      '{STEP_BEAT,  16'h0000, '{16'sh1000, 16'h1000, 1'b1, 1'b1}, 1'b1, '{48'h100_0000, 1'b0}},
      '{STEP_BEAT,  16'h0000, '{16'shF000, 16'h1000, 1'b1, 1'b1}, 1'b1, '{48'h100_0000, 1'b0}},
      '{STEP_BEAT,  16'h0000, '{16'sh8000, 16'h1000, 1'b1, 1'b1}, 1'b1, '{48'h800_0000, 1'b0}},
      '{STEP_BEAT,  16'h0000, '{16'sh7FFF, 16'hFFFF, 1'b1, 1'b1}, 1'b0, '{48'h0, 1'b0}},
      // empty group ahead of a unit group
      '{STEP_BEAT,  16'h0000, '{16'sh0000, 16'hFFFF, 1'b1, 1'b0}, 1'b0, '{48'h0, 1'b0}},
      '{STEP_BEAT,  16'h0000, '{16'sh1000, 16'h1000, 1'b1, 1'b1}, 1'b1, '{48'h100_0000, 1'b0}},
      // 3-4-5 group: only the closing weight counts
      '{STEP_BEAT,  16'h0000, '{16'sh3000, 16'hFFFF, 1'b0, 1'b0}, 1'b0, '{48'h0, 1'b0}},
      '{STEP_BEAT,  16'h0000, '{16'shC000, 16'h1000, 1'b1, 1'b1}, 1'b1, '{48'h500_0000, 1'b0}},
      // row end closes an open group
      '{STEP_BEAT,  16'h0000, '{16'sh1000, 16'h2000, 1'b0, 1'b1}, 1'b1, '{48'h200_0000, 1'b0}},
      '{STEP_BEAT,  16'h0000, '{16'sh1000, 16'h1000, 1'b1, 1'b0}, 1'b0, '{48'h0, 1'b0}},
      '{STEP_BEAT,  16'h0000, '{16'sh2000, 16'h1000, 1'b1, 1'b1}, 1'b1, '{48'h300_0000, 1'b0}},
      '{STEP_BEAT,  16'h0000, '{16'sh0001, 16'hFFFF, 1'b1, 1'b1}, 1'b1, '{48'hFFFF, 1'b0}},
      '{STEP_ALPHA, 16'h0000, '{16'sh0000, 16'h0000, 1'b0, 1'b0}, 1'b0, '{48'h0, 1'b0}},
      '{STEP_BEAT,  16'h0000, '{16'sh1000, 16'h1000, 1'b1, 1'b1}, 1'b1, '{48'h80_0000, 1'b0}},
      '{STEP_BEAT,  16'h0000, '{16'sh8000, 16'hFFFF, 1'b1, 1'b1}, 1'b0, '{48'h0, 1'b0}},
      // alpha above one acts as one
      '{STEP_ALPHA, 16'hFFFF, '{16'sh0000, 16'h0000, 1'b0, 1'b0}, 1'b0, '{48'h0, 1'b0}},
      '{STEP_BEAT,  16'h0000, '{16'sh1000, 16'h1000, 1'b1, 1'b1}, 1'b1, '{48'h100_0000, 1'b0}},
      '{STEP_ALPHA, 16'h4000, '{16'sh0000, 16'h0000, 1'b0, 1'b0}, 1'b0, '{48'h0, 1'b0}},
      '{STEP_BEAT,  16'h0000, '{16'sh2000, 16'h1000, 1'b0, 1'b0}, 1'b0, '{48'h0, 1'b0}},
      '{STEP_BEAT,  16'h0000, '{16'shFFFF, 16'h8000, 1'b0, 1'b1}, 1'b0, '{48'h0, 1'b0}},
      '{STEP_ALPHA, 16'h8001, '{16'sh0000, 16'h0000, 1'b0, 1'b0}, 1'b0, '{48'h0, 1'b0}},
      '{STEP_BEAT,  16'h0000, '{16'sh2000, 16'h1000, 1'b1, 1'b1}, 1'b1, '{48'h200_0000, 1'b0}}
   };

   group_elastic_net_penalty u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #25_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("MISMATCH row %0d: %s", rows_checked, what);
   endtask

   function automatic logic [19:0] floor_root(input logic [39:0] value);
      logic [19:0] root;
      logic [19:0] trial;
      int          bit_pos;
      root = '0;
      for (bit_pos = 19; bit_pos >= 0; bit_pos--) begin
         trial = root | (20'd1 << bit_pos);
         if (40'(trial) * 40'(trial) <= value)
            root = trial;
      end
      return root;
   endfunction

   // Fold one accepted coefficient into the row; done is set when the row closes.
   task automatic absorb_coef(input req_type beat, output bit done, output rsp_type row_out);
      logic [15:0] mag;
      logic [31:0] square;
      logic [40:0] grown;
      logic [15:0] alpha_eff;
      logic [19:0] norm;
      logic [35:0] wn;
      logic [35:0] inner;
      logic [71:0] prod;
      logic [43:0] term;
      logic [48:0] total;
      done = 1'b0;
      row_out = '0;
      mag = beat.coefficient[15] ? 16'(-beat.coefficient) : 16'(beat.coefficient);
      square = 32'(mag) * 32'(mag);
      grown = 41'(acc_square_sum) + 41'(square);
      if (grown > 41'(SQ_MAX)) begin
         acc_square_sum = SQ_MAX;
         acc_clipped = 1'b1;
      end else begin
         acc_square_sum = grown[39:0];
      end
      if (beat.end_of_group || beat.end_of_row) begin
         alpha_eff = (alpha_shadow > ONE_Q15) ? ONE_Q15 : alpha_shadow;
         norm = floor_root(acc_square_sum);
         wn = 36'(beat.group_weight) * 36'(norm);
         inner = (36'(alpha_eff) << 13) + 36'(ONE_Q15 - alpha_eff) * 36'(norm);
         prod = 72'(wn) * 72'(inner);
         term = prod[71:28];
         total = 49'(acc_row_total) + 49'(term);
         if (total > 49'(TOTAL_MAX)) begin
            acc_row_total = TOTAL_MAX;
            acc_clipped = 1'b1;
         end else begin
            acc_row_total = total[47:0];
         end
         acc_square_sum = '0;
      end
      if (beat.end_of_row) begin
         done = 1'b1;
         row_out.penalty = acc_row_total;
         row_out.saturated = acc_clipped;
         acc_square_sum = '0;
         acc_row_total = '0;
         acc_clipped = 1'b0;
      end
   endtask

   // Valid stays high after a beat until the next call decides; settle() drops it.
   task automatic send_coef(input req_type beat, input bit pinned, input rsp_type want);
      bit      done;
      rsp_type row_out;
      @(negedge clock);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      absorb_coef(beat, done, row_out);
      if (done)
         penalty_due.push_back(pinned ? want : row_out);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (penalty_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_alpha(input logic [15:0] value);
      settle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      alpha_shadow = value;
   endtask

   function automatic logic signed [15:0] pick_coef();
      case ($urandom_range(0, 5))
         0: return 16'sh0000;
         1: return $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
         2: return 16'($signed(int'($urandom_range(0, 512))) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_weight();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Max-magnitude group at alpha zero: the square sum clips on its last member.
   task automatic clip_row();
      req_type beat;
      int      grp;
      int      member;
      for (grp = 0; grp < CLIP_GROUPS; grp++) begin
         for (member = 0; member < CLIP_MEMBERS; member++) begin
            beat.coefficient  = 16'sh8000;
            beat.group_weight = 16'hFFFF;
            beat.end_of_group = (member == CLIP_MEMBERS - 1);
            beat.end_of_row   = beat.end_of_group && (grp == CLIP_GROUPS - 1);
            send_coef(beat, 1'b0, '0);
         end
      end
   endtask

   task automatic stream_random_rows(input int beat_budget);
      req_type beat;
      int      sent;
      int      groups;
      int      members;
      int      grp;
      int      member;
      sent = 0;
      while (sent < beat_budget) begin
         groups = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 4);
         for (grp = 0; grp < groups; grp++) begin
            members = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                   : $urandom_range(1, 5);
            for (member = 0; member < members; member++) begin
               beat.coefficient  = pick_coef();
               beat.group_weight = pick_weight();
               beat.end_of_group = (member == members - 1) || ($urandom_range(0, 15) == 0);
               beat.end_of_row   = (grp == groups - 1) && (member == members - 1);
               // drop the group mark on a row end now and then
               if (beat.end_of_row && $urandom_range(0, 3) == 0)
                  beat.end_of_group = 1'b0;
               send_coef(beat, 1'b0, '0);
               sent++;
            end
         end
      end
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 9);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (penalty_due.size() == 0) begin
            note_mismatch($sformatf("unexpected result penalty %h", rsp_data.penalty));
         end else begin
            want = penalty_due.pop_front();
            if (rsp_data.penalty !== want.penalty)
               note_mismatch($sformatf("penalty %h, want %h",
                                       rsp_data.penalty, want.penalty));
            if (rsp_data.saturated !== want.saturated)
               note_mismatch($sformatf("saturated %b, want %b",
                                       rsp_data.saturated, want.saturated));
         end
         rows_checked++;
      end
   end

   initial begin
      int step;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      for (step = 0; step < DIRECTED_STEPS; step++) begin
         if (directed_plan[step].kind == STEP_ALPHA)
            write_alpha(directed_plan[step].alpha);
         else
            send_coef(directed_plan[step].beat, directed_plan[step].pinned,
                      directed_plan[step].want);
      end

      write_alpha(16'h0000);
      clip_row();

      write_alpha(16'($urandom));
      stream_random_rows(PHASE_BEATS);
      write_alpha(16'h0000);
      stream_random_rows(PHASE_BEATS);
      write_alpha(ONE_Q15);
      stream_random_rows(PHASE_BEATS);
      write_alpha(16'($urandom_range(0, 32768)));
      stream_random_rows(PHASE_BEATS);
      write_alpha(16'hFFFF);
      quiet_tail = 1'b1;
      stream_random_rows(PHASE_BEATS);

      settle();
      if (mismatch_count == 0 && penalty_due.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/gennp_pkg.sv
design/gennp_fifo.sv
design/gennp_front.sv
design/gennp_back.sv
design/group_elastic_net_penalty.sv
design/gennp_checker.sv
dv/tb_group_elastic_net_penalty.sv
